### hw/rtl/osd_alpha_overlay_yuv_writer_assert.svh
// assertion macros shared by the overlay writer rtl
// expects i_clk and i_rst_n in the module that uses them
`ifndef OSD_ALPHA_OVERLAY_YUV_WRITER_ASSERT_SVH
`define OSD_ALPHA_OVERLAY_YUV_WRITER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define OAOYW_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("oaoyw check failed");

// next-cycle implication, checked outside reset
`define OAOYW_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("oaoyw check failed");

`endif

### hw/rtl/oaoyw_pkg.sv
// shared types and constants for the osd overlay writer
// no dependencies; imported by every rtl module of the block
package oaoyw_pkg;

    // size limits
    localparam int MAX_IMAGE_WIDTH    = 4096;
    localparam int MAX_IMAGE_HEIGHT   = 4096;
    localparam int MAX_OVERLAY_WIDTH  = 1024;
    localparam int MAX_OVERLAY_HEIGHT = 256;

    // counter widths follow the overlay limits
    localparam int COL_W = $clog2(MAX_OVERLAY_WIDTH);
    localparam int ROW_W = $clog2(MAX_OVERLAY_HEIGHT);

    // field and register widths
    localparam int MODE_W   = 1;
    localparam int DIM_W    = 13;
    localparam int POS_W    = 12;
    localparam int OVW_W    = 11;
    localparam int OVH_W    = 9;
    localparam int COV_W    = 8;
    localparam int ADDR_W   = 25;
    localparam int DATA_W   = 8;
    localparam int WH_W     = 2 * DIM_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_W   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_H   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_W = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAY_H = 3'd6;

    // frame layouts
    localparam logic MODE_PLANAR = 1'b0;
    localparam logic MODE_PACKED = 1'b1;

    localparam logic [DATA_W-1:0] NEUTRAL_CHROMA = 8'd128;

    // queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // one classified pixel that needs three writes
    typedef struct packed {
        logic              mode;
        logic [COV_W-1:0]  cov;
        logic [ADDR_W-1:0] lin;    // w*r + c
        logic [WH_W-1:0]   wh;     // luma plane size
        logic [ADDR_W-1:0] off;    // chroma offset inside a chroma plane
        logic              c_odd;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

### hw/rtl/oaoyw_front.sv
// front end: config registers, overlay counters, pixel classification
// and address precompute; depends on oaoyw_pkg
module oaoyw_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [oaoyw_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [oaoyw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [oaoyw_pkg::COV_W-1:0]      i_cov,
    input  oaoyw_pkg::t_fifo_stat            i_stat,
    output logic                             o_push,
    output oaoyw_pkg::t_entry                o_entry
);
    import oaoyw_pkg::*;

    // config registers
    logic              r_mode;
    logic [DIM_W-1:0]  r_img_w, r_img_h;
    logic [POS_W-1:0]  r_pos_x, r_pos_y;
    logic [OVW_W-1:0]  r_ovl_w;
    logic [OVH_W-1:0]  r_ovl_h;

    // overlay counters
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    // stage a
    logic              r_a_vld;
    logic              r_a_mode;
    logic [COV_W-1:0]  r_a_cov;
    logic [DIM_W-1:0]  r_a_w, r_a_h;
    logic [POS_W:0]    r_a_c, r_a_r;
    logic [POS_W-1:0]  r_a_ysum, r_a_xsum;

    // stage b
    logic              r_b_vld;
    t_entry            r_b_ent;

    logic              a_free, b_free, acc, hit;
    logic [COL_W:0]    ow_c, col_inc;
    logic [ROW_W:0]    oh_c, row_inc;
    logic [DIM_W-1:0]  w_c, h_c;
    logic [POS_W:0]    c_sum, r_sum;
    logic [POS_W-1:0]  ysum, xsum;

    // handshake through the two stages
    always_comb begin
        b_free  = !r_b_vld || !i_stat.full;
        a_free  = !r_a_vld || b_free;
        o_ready = a_free;
        acc     = i_valid && a_free;
        o_push  = r_b_vld && !i_stat.full;
        o_entry = r_b_ent;
    end

    // clamp overlay and frame sizes
    always_comb begin
        if (r_ovl_w == '0) begin
            ow_c = (COL_W+1)'(1);
        end else if (int'(r_ovl_w) > MAX_OVERLAY_WIDTH) begin
            ow_c = (COL_W+1)'(MAX_OVERLAY_WIDTH);
        end else begin
            ow_c = (COL_W+1)'(r_ovl_w);
        end
        if (r_ovl_h == '0) begin
            oh_c = (ROW_W+1)'(1);
        end else if (int'(r_ovl_h) > MAX_OVERLAY_HEIGHT) begin
            oh_c = (ROW_W+1)'(MAX_OVERLAY_HEIGHT);
        end else begin
            oh_c = (ROW_W+1)'(r_ovl_h);
        end
        w_c = (int'(r_img_w) > MAX_IMAGE_WIDTH)  ? DIM_W'(MAX_IMAGE_WIDTH)  : r_img_w;
        h_c = (int'(r_img_h) > MAX_IMAGE_HEIGHT) ? DIM_W'(MAX_IMAGE_HEIGHT) : r_img_h;
    end

    // frame position and classification of the current pixel
    always_comb begin
        c_sum = {1'b0, r_pos_x} + (POS_W+1)'(r_col);
        r_sum = {1'b0, r_pos_y} + (POS_W+1)'(r_row);
        ysum  = POS_W'(r_pos_y >> 1) + POS_W'(r_row >> 1);
        xsum  = POS_W'(r_pos_x >> 1) + POS_W'(r_col >> 1);
        hit   = (i_cov != '0) && ({1'b0, c_sum} < {1'b0, w_c})
                && ({1'b0, r_sum} < {1'b0, h_c});
    end

    // counter advance, also on transparent or clipped pixels
    always_comb begin
        col_inc = {1'b0, r_col} + (COL_W+1)'(1);
        row_inc = {1'b0, r_row} + (ROW_W+1)'(1);
        n_col   = r_col;
        n_row   = r_row;
        if (acc) begin
            if (col_inc >= ow_c) begin
                n_col = '0;
                n_row = (row_inc >= oh_c) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
            end
        end
    end

    // control state and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_PLANAR;
            r_img_w <= DIM_W'(1920);
            r_img_h <= DIM_W'(1080);
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_ovl_w <= OVW_W'(1024);
            r_ovl_h <= OVH_W'(64);
            r_col   <= '0;
            r_row   <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MODE:      r_mode  <= i_cfg_data[0];
                    CFG_IMAGE_W:   r_img_w <= i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_H:   r_img_h <= i_cfg_data[DIM_W-1:0];
                    CFG_POS_X:     r_pos_x <= i_cfg_data[POS_W-1:0];
                    CFG_POS_Y:     r_pos_y <= i_cfg_data[POS_W-1:0];
                    CFG_OVERLAY_W: r_ovl_w <= i_cfg_data[OVW_W-1:0];
                    CFG_OVERLAY_H: r_ovl_h <= i_cfg_data[OVH_W-1:0];
                    default: ;
                endcase
            end
            r_col <= n_col;
            r_row <= n_row;
            if (a_free) begin
                r_a_vld <= acc && hit;
            end
            if (b_free) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    // stage a payload
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_mode <= r_mode;
            r_a_cov  <= i_cov;
            r_a_w    <= w_c;
            r_a_h    <= h_c;
            r_a_c    <= c_sum;
            r_a_r    <= r_sum;
            r_a_ysum <= ysum;
            r_a_xsum <= xsum;
        end
    end

    // stage b payload: the multiplications
    always_ff @(posedge i_clk) begin
        if (b_free && r_a_vld) begin
            r_b_ent.mode  <= r_a_mode;
            r_b_ent.cov   <= r_a_cov;
            r_b_ent.lin   <= ADDR_W'(r_a_w * r_a_r) + ADDR_W'(r_a_c);
            r_b_ent.wh    <= WH_W'(r_a_w * r_a_h);
            r_b_ent.off   <= ADDR_W'(r_a_w[DIM_W-1:1] * r_a_ysum) + ADDR_W'(r_a_xsum);
            r_b_ent.c_odd <= r_a_c[0];
        end
    end

endmodule

### hw/rtl/oaoyw_fifo.sv
// short queue of classified pixels between front and back
// depends on oaoyw_pkg and the assertion macro header
`include "osd_alpha_overlay_yuv_writer_assert.svh"

module oaoyw_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  oaoyw_pkg::t_entry     i_entry,
    input  logic                  i_pop,
    output oaoyw_pkg::t_entry     o_entry,
    output oaoyw_pkg::t_fifo_stat o_stat
);
    import oaoyw_pkg::*;

    t_entry                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr, r_rd;
    logic [FIFO_CNT_W-1:0] r_cnt;

    // status and head of queue
    always_comb begin
        o_stat.full  = (r_cnt == FIFO_CNT_W'(FIFO_DEPTH));
        o_stat.empty = (r_cnt == '0);
        o_entry      = r_mem[r_rd];
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (int'(r_wr) == FIFO_DEPTH - 1) ? '0 : r_wr + FIFO_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (int'(r_rd) == FIFO_DEPTH - 1) ? '0 : r_rd + FIFO_PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + FIFO_CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - FIFO_CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    `OAOYW_ASSERT_IMPL(a_no_overflow, i_push, r_cnt != FIFO_CNT_W'(FIFO_DEPTH))
    `OAOYW_ASSERT_IMPL(a_no_underflow, i_pop, r_cnt != '0)

endmodule

### hw/rtl/oaoyw_back.sv
// back end: expands one classified pixel into three byte writes
// through the output register; depends on oaoyw_pkg and the assertion header
`include "osd_alpha_overlay_yuv_writer_assert.svh"

module oaoyw_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  oaoyw_pkg::t_fifo_stat         i_stat,
    input  oaoyw_pkg::t_entry             i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [oaoyw_pkg::ADDR_W-1:0]  o_addr,
    output logic [oaoyw_pkg::DATA_W-1:0]  o_data,
    output logic                          o_last
);
    import oaoyw_pkg::*;

    typedef enum logic [2:0] {
        PH_Y = 3'b001,
        PH_U = 3'b010,
        PH_V = 3'b100
    } t_phase;

    t_entry            r_ent;
    logic              r_busy;
    t_phase            r_ph, n_ph;
    logic              r_out_vld;
    logic [ADDR_W-1:0] r_out_addr;
    logic [DATA_W-1:0] r_out_data;
    logic              r_out_last;

    logic              out_free, step, last_step;
    logic [ADDR_W-1:0] ph_addr, ya, u_addr, v_addr;
    logic [DATA_W-1:0] ph_data;
    logic [WH_W-1:0]   v_base;

    // issue control
    always_comb begin
        out_free  = !r_out_vld || i_ready;
        step      = r_busy && out_free;
        last_step = step && (r_ph == PH_V);
        o_pop     = !i_stat.empty && (!r_busy || last_step);
        o_valid   = r_out_vld;
        o_addr    = r_out_addr;
        o_data    = r_out_data;
        o_last    = r_out_last;
    end

    // addresses of the three writes
    always_comb begin
        ya     = {r_ent.lin[ADDR_W-2:0], 1'b0};
        v_base = r_ent.wh + (r_ent.wh >> 2);
        u_addr = ADDR_W'(r_ent.wh) + r_ent.off;
        v_addr = ADDR_W'(v_base) + r_ent.off;
        ph_data = NEUTRAL_CHROMA;
        n_ph    = r_ph;
        unique case (r_ph)
            PH_Y: begin
                ph_addr = (r_ent.mode == MODE_PACKED) ? ya : r_ent.lin;
                ph_data = r_ent.cov;
                n_ph    = PH_U;
            end
            PH_U: begin
                ph_addr = (r_ent.mode == MODE_PACKED) ? (ya + ADDR_W'(1)) : u_addr;
                n_ph    = PH_V;
            end
            PH_V: begin
                if (r_ent.mode == MODE_PACKED) begin
                    ph_addr = r_ent.c_odd ? (ya - ADDR_W'(1)) : (ya + ADDR_W'(3));
                end else begin
                    ph_addr = v_addr;
                end
                n_ph = PH_Y;
            end
            default: begin
                ph_addr = r_ent.lin;
                n_ph    = PH_Y;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_ph      <= PH_Y;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_ph   <= PH_Y;
            end else if (last_step) begin
                r_busy <= 1'b0;
                r_ph   <= PH_Y;
            end else if (step) begin
                r_ph <= n_ph;
            end
            if (out_free) begin
                r_out_vld <= step;
            end
        end
    end

    // entry and output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_entry;
        end
        if (step) begin
            r_out_addr <= ph_addr;
            r_out_data <= ph_data;
            r_out_last <= (r_ph == PH_V);
        end
    end

    `OAOYW_ASSERT_NEXT(a_beats_follow, r_out_vld && i_ready && !r_out_last, r_out_vld)
    `OAOYW_ASSERT_IMPL(a_last_chroma, r_out_vld && r_out_last, r_out_data == NEUTRAL_CHROMA)

endmodule

### hw/rtl/osd_alpha_overlay_yuv_writer.sv
// top level of the osd overlay writer: front, queue and back
// depends on oaoyw_pkg, oaoyw_front, oaoyw_fifo and oaoyw_back
//
// usage
//   slave stream: one coverage byte per item (tdata[7:0]) in overlay raster
//   order; overlay row and column counters advance on every accepted item.
//   master stream: byte writes into the frame buffer, tdata[24:0] address,
//   tdata[32:25] data, tlast on the third write of a pixel.
//   config port: write enable, register index, 13-bit data; write only
//   while the block is idle.
// write path and rate
//   a pixel that lands inside the frame and is not transparent gives three
//   writes, one per cycle while the receiver is ready; it passes stage a,
//   stage b, the queue and the output register. the single master port sets
//   the sustained rate of drawn pixels; transparent or clipped pixels are
//   accepted and produce no write.
// reset and stall
//   synchronous reset restores the register defaults and clears the
//   counters and the queue. when the receiver stalls the current write is
//   held, the four-entry queue fills and then the slave ready drops.
module osd_alpha_overlay_yuv_writer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [oaoyw_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [oaoyw_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    input  logic [oaoyw_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,   // coverage
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    output logic [oaoyw_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,   // write_address, write_data
    output logic                               o_m_axis_tlast
);
    import oaoyw_pkg::*;

    logic              push, pop;
    t_entry            front_ent, head_ent;
    t_fifo_stat        stat;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;

    // front end
    oaoyw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_s_axis_tvalid),
        .o_ready    (o_s_axis_tready),
        .i_cov      (i_s_axis_tdata[COV_W-1:0]),
        .i_stat     (stat),
        .o_push     (push),
        .o_entry    (front_ent)
    );

    // queue
    oaoyw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_ent),
        .i_pop   (pop),
        .o_entry (head_ent),
        .o_stat  (stat)
    );

    // back end
    oaoyw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .i_entry (head_ent),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_addr  (wr_addr),
        .o_data  (wr_data),
        .o_last  (o_m_axis_tlast)
    );

    // pack output data, zero fill to whole bytes
    assign o_m_axis_tdata = {(OUT_TDATA_W-ADDR_W-DATA_W)'(0), wr_data, wr_addr};

endmodule

### bench/osd_overlay_write_checker.sv
`timescale 1ns / 100ps
// checker for the osd overlay writer: mirrors the register file and overlay counters,
// predicts the frame-buffer writes of every accepted item and compares them in order
// depends on oaoyw_pkg for widths, register indexes and layout codes
module osd_overlay_write_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [oaoyw_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [oaoyw_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                                i_s_axis_tvalid,
    input  logic                                i_s_axis_tready,
    input  logic [oaoyw_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,   // coverage
    input  logic                                i_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [oaoyw_pkg::OUT_TDATA_W-1:0]   i_m_axis_tdata,   // write_address, write_data
    input  logic                                i_m_axis_tlast,
    output int                                  o_mismatch_count,
    output int                                  o_writes_pending,
    output int                                  o_writes_checked
);
    import oaoyw_pkg::*;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_frame_write;

    // mirrored registers and overlay position
    logic             layout_mode  = MODE_PLANAR;
    logic [DIM_W-1:0] frame_w      = 13'd1920;
    logic [DIM_W-1:0] frame_h      = 13'd1080;
    logic [POS_W-1:0] ovl_x        = '0;
    logic [POS_W-1:0] ovl_y        = '0;
    logic [OVW_W-1:0] ovl_w        = 11'd1024;
    logic [OVH_W-1:0] ovl_h        = 9'd64;
    int unsigned      col_idx      = 0;
    int unsigned      row_idx      = 0;

    t_frame_write     expected_writes [$];
    int               mismatch_total = 0;
    int               checked_total  = 0;

    assign o_mismatch_count = mismatch_total;
    assign o_writes_pending = expected_writes.size();
    assign o_writes_checked = checked_total;

    task automatic report_mismatch(input string msg);
        mismatch_total++;
        if (mismatch_total <= 30)
            $display("[%0t ns] overlay write check: %s", $time, msg);
    endtask

    function automatic int unsigned clamp_to(input int unsigned v, input int unsigned lo,
                                             input int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void queue_write(input longint unsigned addr,
                                        input logic [DATA_W-1:0] data, input logic last);
        t_frame_write wr;
        wr.addr = addr[ADDR_W-1:0];
        wr.data = data;
        wr.last = last;
        expected_writes.push_back(wr);
    endfunction

    // three writes for a visible nonzero pixel, then advance the overlay counters
    function automatic void predict_pixel_writes(input logic [COV_W-1:0] cov);
        int unsigned     ow;
        int unsigned     oh;
        longint unsigned w;
        longint unsigned h;
        longint unsigned c;
        longint unsigned r;
        longint unsigned lin;
        longint unsigned off;
        ow = clamp_to(ovl_w, 1, MAX_OVERLAY_WIDTH);
        oh = clamp_to(ovl_h, 1, MAX_OVERLAY_HEIGHT);
        w  = clamp_to(frame_w, 0, MAX_IMAGE_WIDTH);
        h  = clamp_to(frame_h, 0, MAX_IMAGE_HEIGHT);
        c  = ovl_x + col_idx;
        r  = ovl_y + row_idx;
        if (cov != '0 && c < w && r < h) begin
            lin = w * r + c;
            if (layout_mode == MODE_PLANAR) begin
                // chroma rows and columns at half resolution
                off = (w / 2) * (ovl_y / 2 + row_idx / 2) + ovl_x / 2 + col_idx / 2;
                queue_write(lin, cov, 1'b0);
                queue_write(w * h + off, NEUTRAL_CHROMA, 1'b0);
                queue_write(w * h * 5 / 4 + off, NEUTRAL_CHROMA, 1'b1);
            end else begin
                // packed y u y v: partner chroma sits before odd or after even columns
                queue_write(2 * lin, cov, 1'b0);
                queue_write(2 * lin + 1, NEUTRAL_CHROMA, 1'b0);
                if (c[0])
                    queue_write(2 * lin - 1, NEUTRAL_CHROMA, 1'b1);
                else
                    queue_write(2 * lin + 3, NEUTRAL_CHROMA, 1'b1);
            end
        end
        if (col_idx + 1 >= ow) begin
            col_idx = 0;
            if (row_idx + 1 >= oh)
                row_idx = 0;
            else
                row_idx++;
        end else begin
            col_idx++;
        end
    endfunction

    // sample both channels and the register port at each rising edge
    always @(posedge i_clk) begin
        t_frame_write want;
        logic [ADDR_W-1:0] got_addr;
        logic [DATA_W-1:0] got_data;
        got_addr = i_m_axis_tdata[ADDR_W-1:0];
        got_data = i_m_axis_tdata[ADDR_W +: DATA_W];
        if (!i_rst_n) begin
            layout_mode = MODE_PLANAR;
            frame_w     = 13'd1920;
            frame_h     = 13'd1080;
            ovl_x       = '0;
            ovl_y       = '0;
            ovl_w       = 11'd1024;
            ovl_h       = 9'd64;
            col_idx     = 0;
            row_idx     = 0;
            expected_writes.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODE:      layout_mode = i_cfg_data[0];
                    CFG_IMAGE_W:   frame_w     = i_cfg_data[DIM_W-1:0];
                    CFG_IMAGE_H:   frame_h     = i_cfg_data[DIM_W-1:0];
                    CFG_POS_X:     ovl_x       = i_cfg_data[POS_W-1:0];
                    CFG_POS_Y:     ovl_y       = i_cfg_data[POS_W-1:0];
                    CFG_OVERLAY_W: ovl_w       = i_cfg_data[OVW_W-1:0];
                    CFG_OVERLAY_H: ovl_h       = i_cfg_data[OVH_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                predict_pixel_writes(i_s_axis_tdata[COV_W-1:0]);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_writes.size() == 0) begin
                    report_mismatch($sformatf("write to 0x%0h data 0x%0h with none expected",
                                              got_addr, got_data));
                end else begin
                    want = expected_writes.pop_front();
                    checked_total++;
                    if (got_addr !== want.addr)
                        report_mismatch($sformatf("write_address expected 0x%0h, got 0x%0h",
                                                  want.addr, got_addr));
                    if (got_data !== want.data)
                        report_mismatch($sformatf("write_data at 0x%0h expected 0x%0h, got 0x%0h",
                                                  want.addr, want.data, got_data));
                    if (i_m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last at 0x%0h expected %0b, got %0b",
                                                  want.addr, want.last, i_m_axis_tlast));
                end
            end
        end
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// top of the overlay writer bench: clock, reset, register setups and coverage stimulus
// depends on oaoyw_pkg, osd_alpha_overlay_yuv_writer and osd_overlay_write_checker
module testbench;
    import oaoyw_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 16;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx       = CFG_MODE;
    logic [CFG_DATA_W-1:0]  i_cfg_data      = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;   // coverage
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;         // write_address, write_data
    logic                   o_m_axis_tlast;

    int mismatch_count;
    int writes_pending;
    int writes_checked;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_done      = 0;
    int hold_left      = 0;
    int items_sent     = 0;
    int setups_done    = 0;
    int cycle_count    = 0;

    osd_alpha_overlay_yuv_writer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    osd_overlay_write_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_s_axis_tvalid  (i_s_axis_tvalid),
        .i_s_axis_tready  (o_s_axis_tready),
        .i_s_axis_tdata   (i_s_axis_tdata),
        .i_m_axis_tvalid  (o_m_axis_tvalid),
        .i_m_axis_tready  (i_m_axis_tready),
        .i_m_axis_tdata   (o_m_axis_tdata),
        .i_m_axis_tlast   (o_m_axis_tlast),
        .o_mismatch_count (mismatch_count),
        .o_writes_pending (writes_pending),
        .o_writes_checked (writes_checked)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d writes still due", cycle_count,
                     writes_pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // write-side receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_asked != hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = hold_asked;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic apply_setup(input logic m, input int unsigned iw, input int unsigned ih,
                               input int unsigned px, input int unsigned py,
                               input int unsigned ow, input int unsigned oh);
        cfg_write(CFG_MODE, m);
        cfg_write(CFG_IMAGE_W, iw);
        cfg_write(CFG_IMAGE_H, ih);
        cfg_write(CFG_POS_X, px);
        cfg_write(CFG_POS_Y, py);
        cfg_write(CFG_OVERLAY_W, ow);
        cfg_write(CFG_OVERLAY_H, oh);
        setups_done++;
    endtask

    // one coverage item, with an optional idle gap ahead of it
    task automatic send_pixel(input logic [COV_W-1:0] cov);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= cov;
        do @(posedge i_clk); while (!o_s_axis_tready);
        items_sent++;
    endtask

    // drop valid, let every due write arrive and the pipeline empty
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        // let the checker queue the writes of the last item first
        @(posedge i_clk);
        while (writes_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int          ph;
        int          k;
        int unsigned iw;
        int unsigned ih;
        int unsigned px;
        int unsigned py;
        int unsigned ow;
        int unsigned oh;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: transparent, full and minimal coverage
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        wait_drained();

        // planar small frame, overlay runs past the right and bottom edges
        apply_setup(MODE_PLANAR, 16, 8, 13, 6, 4, 3);
        for (k = 0; k < 10; k++)
            send_pixel((k == 4) ? 8'h00 : 8'hFF - 8'(k * 37));
        wait_drained();

        // packed odd-width frame: both column parities and the wrap to the next line
        apply_setup(MODE_PACKED, 7, 6, 3, 4, 5, 2);
        for (k = 0; k < 8; k++)
            send_pixel((k == 2) ? 8'h00 : 8'h55 ^ 8'(k * 51));
        wait_drained();

        // oversized frame and overlay registers, last pixels of the largest frame
        apply_setup(MODE_PACKED, 8191, 8191, 4090, 4094, 2047, 511);
        send_pixel(8'h80);
        send_pixel(8'h7F);
        wait_drained();

        // zero frame width drops everything
        apply_setup(MODE_PLANAR, 0, 8, 0, 0, 4, 2);
        send_pixel(8'hAA);
        send_pixel(8'hFE);
        wait_drained();

        // random setups, rotating through the idle patterns
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            case ($urandom_range(9))
                0:       iw = 0;
                1:       iw = MAX_IMAGE_WIDTH;
                2:       iw = 8191;
                3:       iw = $urandom_range(8191);
                default: iw = $urandom_range(40, 2);
            endcase
            case ($urandom_range(9))
                0:       ih = 1;
                1:       ih = MAX_IMAGE_HEIGHT;
                2:       ih = 8191;
                3:       ih = $urandom_range(8191);
                default: ih = $urandom_range(20, 2);
            endcase
            px = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(40);
            py = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(20);
            case ($urandom_range(7))
                0:       ow = 0;
                1:       ow = 2047;
                2:       ow = MAX_OVERLAY_WIDTH;
                default: ow = $urandom_range(12, 1);
            endcase
            case ($urandom_range(7))
                0:       oh = 0;
                1:       oh = 511;
                2:       oh = MAX_OVERLAY_HEIGHT;
                default: oh = $urandom_range(6, 1);
            endcase
            apply_setup(1'(ph[0] ^ $urandom_range(1)), iw, ih, px, py, ow, oh);
            for (k = 0; k < PHASE_ITEMS; k++)
                send_pixel(($urandom_range(4) == 0) ? 8'h00 : 8'($urandom_range(255, 1)));
            wait_drained();
        end

        // receiver holds off while items keep coming, so the queue fills up
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        apply_setup(MODE_PLANAR, 32, 16, 2, 1, 8, 4);
        hold_asked++;
        for (k = 0; k < 16; k++)
            send_pixel(8'($urandom_range(255, 1)));
        wait_drained();

        $display("%0d coverage items sent over %0d register setups, both frame layouts",
                 items_sent, setups_done);
        $display("%0d frame writes compared, including a %0d-cycle receiver hold-off",
                 writes_checked, HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
